FILE: rtl/stse_pkg.sv
// Package for the sorted table exact search unit.
// Holds the fixed field widths, operation codes and result constants.
// No dependencies; the interfaces and the top level import it.
`default_nettype none

package stse_pkg;

  // Fixed widths of the channel payload fields.
  localparam int FUNC_W  = 1;
  localparam int LIDX_W  = 10;
  localparam int DATA_W  = 64;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 11;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

  // Entry count after reset and the smallest count that is honored.
  localparam logic [CFG_W-1:0] COUNT_RESET = 11'd2;
  localparam int               MIN_COUNT   = 2;

  // Index reported when no entry matches the key.
  localparam logic signed [IDX_W-1:0] MISS_INDEX = -11'sd1;

endpackage

`default_nettype wire

FILE: rtl/stse_if.sv
// Channel interfaces of the sorted table exact search unit.
// Input items, result items and configuration writes; uses stse_pkg widths.
`default_nettype none

// Input channel: table loads and key searches.
interface stse_in_if import stse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [LIDX_W-1:0]        load_index;
  logic signed [DATA_W-1:0] entry_value;
  logic signed [DATA_W-1:0] search_key;
  logic                     last_key;

  modport source (output valid, func, load_index, entry_value, search_key, last_key,
                  input ready);
  modport sink   (input valid, func, load_index, entry_value, search_key, last_key,
                  output ready);
endinterface

// Result channel: one transaction per search.
interface stse_out_if import stse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IDX_W-1:0] match_index;
  logic                    found;
  logic                    batch_end;

  modport source (output valid, match_index, found, batch_end, input ready);
  modport sink   (input valid, match_index, found, batch_end, output ready);
endinterface

// Configuration write channel for the entry count register.
interface stse_cfg_if import stse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/stse_ram.sv
// Generic single-port RAM with a registered read port.
// Used for the value table of the search unit; no package dependency.
`default_nettype none

module stse_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Registered read port; data follows in the cycle after re_i.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_table_exact_search_unit.sv
// Sorted table exact search unit: top level with the search sequencer.
// Depends on stse_pkg, the interfaces in stse_if and the RAM in stse_ram.
//
// Usage:
//   in_i carries two kinds of transactions. A load (func = FUNC_LOAD) writes
//   entry_value into table position load_index and gives no result. A search
//   (func = FUNC_SEARCH) looks search_key up in the first
//   entry_count positions, which must be loaded and sorted ascending, and
//   gives one transaction on out_o: match_index (or -1), found and batch_end.
//   cfg_i writes entry_count and is always ready; it is to be written by the
//   user only while idle, which the block does not enforce. A search reads
//   the entry at the split index, then the start position, then halves its
//   step from half the largest power of two below entry_count down to one,
//   ending early on a match. The single table port is the limit: one read
//   per step. One search is in flight at a time; in_i is ready when idle.
//   A finished result sits in an output register, so the next item is taken
//   while out_o is stalled. If the result register is still full when the
//   next search finishes, the sequencer holds that result until it drains.
//   Reset clears the sequencer and the result register and sets entry_count
//   to 2. The table is not cleared; reading an unloaded entry is undefined.
`default_nettype none

module sorted_table_exact_search_unit
  import stse_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_BITS  = 64
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  stse_in_if.sink      in_i,
  stse_cfg_if.sink     cfg_i,
  stse_out_if.source   out_o
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int NW = AW + 1;
  localparam int CW = (NW > CFG_W) ? NW : CFG_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPLIT = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [CFG_W-1:0]            count_q;
  logic signed [VALUE_BITS-1:0] key_q, key_d;
  logic                        last_q, last_d;
  logic [AW-1:0]               pos_q, pos_d;
  logic [AW-1:0]               step_q, step_d;
  logic [AW-1:0]               res_idx_q, res_idx_d;
  logic                        res_hit_q, res_hit_d;

  logic                        out_valid_q;
  logic signed [IDX_W-1:0]     out_index_q;
  logic                        out_found_q;
  logic                        out_end_q;

  logic [CW-1:0]               count_ext;
  logic [CW-1:0]               count_clamp;
  logic [NW-1:0]               num;
  logic [AW-1:0]               num_m1;
  logic [AW-1:0]               pw;
  logic [AW-1:0]               split;

  logic                        in_acc;
  logic                        out_free;
  logic                        load_ok;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_addr;
  logic [VALUE_BITS-1:0]       ram_wdata;
  logic [VALUE_BITS-1:0]       ram_rdata;
  logic signed [VALUE_BITS-1:0] rd_val;
  logic [AW-1:0]               cand;
  logic [AW-1:0]               pos_nx, step_nx;

  logic                        fin;
  logic                        fin_hit;
  logic [AW-1:0]               fin_idx;
  logic                        out_ld;
  logic                        out_ld_hit;
  logic [AW-1:0]               out_ld_idx;

  // Configuration register; the port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.entry_count;
    end
  end

  // Effective count, clamped to the table size and to the minimum of two.
  assign count_ext = CW'(count_q);

  always_comb begin
    if (count_ext < CW'(MIN_COUNT)) begin
      count_clamp = CW'(MIN_COUNT);
    end else if (count_ext > CW'(MAX_ENTRIES)) begin
      count_clamp = CW'(MAX_ENTRIES);
    end else begin
      count_clamp = count_ext;
    end
  end

  assign num    = NW'(count_clamp);
  assign num_m1 = AW'(num - NW'(1));

  // Largest power of two not above count - 1: the top set bit of count - 1.
  always_comb begin
    pw = '0;
    for (int i = 0; i < AW; i++) begin
      if (num_m1[i]) begin
        pw    = '0;
        pw[i] = 1'b1;
      end
    end
  end

  assign split = AW'(num - NW'(pw));

  // Handshake terms.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign load_ok    = (CW'(in_i.load_index) < CW'(MAX_ENTRIES));

  assign rd_val = $signed(ram_rdata);
  assign cand   = pos_q + step_q;

  // Search sequencer: at most one table read per state, compared in the next state.
  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    last_d    = last_q;
    pos_d     = pos_q;
    step_d    = step_q;
    res_idx_d = res_idx_q;
    res_hit_d = res_hit_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = '0;
    ram_wdata = in_i.entry_value[VALUE_BITS-1:0];
    pos_nx    = pos_q;
    step_nx   = step_q;
    fin       = 1'b0;
    fin_hit   = 1'b0;
    fin_idx   = pos_q;
    out_ld     = 1'b0;
    out_ld_hit = res_hit_q;
    out_ld_idx = res_idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.func == FUNC_SEARCH) begin
            key_d    = $signed(in_i.search_key[VALUE_BITS-1:0]);
            last_d   = in_i.last_key;
            ram_re   = 1'b1;
            ram_addr = split;
            state_d  = S_SPLIT;
          end else if (load_ok) begin
            ram_we   = 1'b1;
            ram_addr = AW'(in_i.load_index);
          end
        end
      end
      S_SPLIT: begin
        // Pick the start position from the entry at the split index.
        pos_d    = (key_q >= rd_val) ? split : '0;
        ram_re   = 1'b1;
        ram_addr = pos_d;
        state_d  = S_START;
      end
      S_START: begin
        if (rd_val == key_q) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
          fin_idx = pos_q;
        end else if ((pw >> 1) == '0) begin
          fin = 1'b1;
        end else begin
          step_d   = pw >> 1;
          ram_re   = 1'b1;
          ram_addr = pos_q + step_d;
          state_d  = S_STEP;
        end
      end
      S_STEP: begin
        if (rd_val == key_q) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
          fin_idx = cand;
        end else begin
          pos_nx  = (key_q > rd_val) ? cand : pos_q;
          step_nx = step_q >> 1;
          if (step_nx == '0) begin
            fin = 1'b1;
          end else begin
            pos_d    = pos_nx;
            step_d   = step_nx;
            ram_re   = 1'b1;
            ram_addr = pos_nx + step_nx;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A finished search goes to the result register, or waits if it is full.
    if (fin) begin
      res_hit_d = fin_hit;
      res_idx_d = fin_idx;
      if (out_free) begin
        out_ld     = 1'b1;
        out_ld_hit = fin_hit;
        out_ld_idx = fin_idx;
        state_d    = S_IDLE;
      end else begin
        state_d = S_HOLD;
      end
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search working registers.
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    last_q    <= last_d;
    pos_q     <= pos_d;
    step_q    <= step_d;
    res_idx_q <= res_idx_d;
    res_hit_q <= res_hit_d;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_index_q <= out_ld_hit ? $signed(IDX_W'(out_ld_idx)) : MISS_INDEX;
      out_found_q <= out_ld_hit;
      out_end_q   <= last_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.match_index = out_index_q;
  assign out_o.found       = out_found_q;
  assign out_o.batch_end   = out_end_q;

  // Value table.
  stse_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Every table read stays inside the entries in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (NW'(ram_addr) < num))
    else $error("table read beyond entry count");

  // The step register is a single bit while halving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> $onehot(step_q))
    else $error("search step is not a power of two");

  // An accepted search starts with the split read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.func == FUNC_SEARCH) |=> (state_q == S_SPLIT))
    else $error("search did not start at the split index");

  // A result appears only from a search step or the hold state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      $past(state_q == S_START || state_q == S_STEP || state_q == S_HOLD))
    else $error("result without a search");

  // A found result never carries the miss index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_found_q) |-> (out_index_q != MISS_INDEX))
    else $error("found result with miss index");

endmodule

`default_nettype wire
